### rtl/alc_pkg.sv
// ----------------------------------------------------------------------------
// alc_pkg
// Shared types and codes for the ordered list with cursor: operation codes,
// status codes, the result record and the memory control record.
// ----------------------------------------------------------------------------
package alc_pkg;

    // Operation codes carried by a request
    typedef enum logic [3:0] {
        OP_INSERT   = 4'd0,
        OP_APPEND   = 4'd1,
        OP_DELETE   = 4'd2,
        OP_READ     = 4'd3,
        OP_START    = 4'd4,
        OP_ADVANCE  = 4'd5,
        OP_READ_CUR = 4'd6,
        OP_ADD      = 4'd7,
        OP_REMOVE   = 4'd8
    } op_t;

    // Status codes returned with every result
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2,
        ST_BADCUR = 2'd3
    } status_t;

    // Port widths of the result fields
    localparam int DATA_PORT_W  = 32;
    localparam int COUNT_PORT_W = 7;
    localparam int POS_PORT_W   = 7;

    // One result record
    typedef struct packed {
        logic [DATA_PORT_W-1:0]  data;
        status_t                 status;
        logic [COUNT_PORT_W-1:0] count;
        logic                    cursor_ok;
    } alc_result_t;

    // Memory port strobes
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } alc_mem_ctl_t;

endpackage

### rtl/array_list_with_cursor.sv
// ----------------------------------------------------------------------------
// array_list_with_cursor
// Ordered list with length count and cursor, held in one entry memory.
// ----------------------------------------------------------------------------
// Each request carries one operation and yields one result. Insert, add,
// delete and remove shift the later entries through the entry memory (one
// read port, one write port), one entry per cycle. The most entries move on
// an insert or add at the head of a list one short of full. Reads pass through
// an extra state that captures the read data before the result is offered.
// The next request is taken as soon as the sequencer is free, while the
// previous result may still wait in the output register. Entries are kept at
// DATA_WIDTH bits (at most 32) and read back zero-extended; count reports
// the low 7 bits of the length. The memory needs no clearing after reset.
module array_list_with_cursor #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic [3:0]                          operation,
    input  logic [alc_pkg::POS_PORT_W-1:0]      position,
    input  logic [alc_pkg::DATA_PORT_W-1:0]     value,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output logic [alc_pkg::DATA_PORT_W-1:0]     data,
    output logic [1:0]                          status,
    output logic [alc_pkg::COUNT_PORT_W-1:0]    count,
    output logic                                cursor_ok
);
    import alc_pkg::*;

    localparam int SW = (DATA_WIDTH < DATA_PORT_W) ? DATA_WIDTH : DATA_PORT_W;
    localparam int AW = $clog2(CAPACITY);
    localparam int UW = $clog2(CAPACITY + 1);

    alc_mem_ctl_t  mem_ctl;
    logic [AW-1:0] mem_raddr;
    logic [AW-1:0] mem_waddr;
    logic [SW-1:0] mem_wdata;
    logic [SW-1:0] mem_rdata;

    logic          res_valid;
    logic          res_ready;
    alc_result_t   res;

    logic          obuf_valid_reg, obuf_valid_next;
    alc_result_t   obuf_reg;

    alc_store #(
        .DEPTH (CAPACITY),
        .DW    (SW),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .ctl   (mem_ctl),
        .raddr (mem_raddr),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    alc_ctrl #(
        .CAPACITY (CAPACITY),
        .SW       (SW),
        .AW       (AW),
        .UW       (UW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .operation (operation),
        .position  (position),
        .value     (value),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_ctl   (mem_ctl),
        .mem_raddr (mem_raddr),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    // Take a result when the output register is empty or draining
    assign res_ready = !obuf_valid_reg || rsp_ready;

    always_comb
    begin
        obuf_valid_next = obuf_valid_reg;
        if (res_valid && res_ready)
        begin
            obuf_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            obuf_valid_next = 1'b0;
        end
    end

    // Hold the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obuf_valid_reg <= 1'b0;
        end
        else
        begin
            obuf_valid_reg <= obuf_valid_next;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            obuf_reg <= res;
        end
    end

    assign rsp_valid = obuf_valid_reg;
    assign data      = obuf_reg.data;
    assign status    = obuf_reg.status;
    assign count     = obuf_reg.count;
    assign cursor_ok = obuf_reg.cursor_ok;

`ifndef SYNTH
    // A waiting result is never overwritten
    a_obuf_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(obuf_reg)))
        else $error("pending result lost");

    // A result is never loaded into a full register that is not draining
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && obuf_valid_reg && !rsp_ready) |-> !res_ready)
        else $error("result register overrun");

    // A result taken from the sequencer is presented on the next cycle
    a_done_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> rsp_valid)
        else $error("delivered result not presented");
`endif

endmodule

### rtl/alc_store.sv
// ----------------------------------------------------------------------------
// alc_store
// Entry memory: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module alc_store #(
    parameter int DEPTH = 64,
    parameter int DW    = 32,
    parameter int AW    = 6
) (
    input  logic                  clk,
    input  alc_pkg::alc_mem_ctl_t ctl,
    input  logic [AW-1:0]         raddr,
    input  logic [AW-1:0]         waddr,
    input  logic [DW-1:0]         wdata,
    output logic [DW-1:0]         rdata
);
    import alc_pkg::*;

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/alc_ctrl.sv
// ----------------------------------------------------------------------------
// alc_ctrl
// Request sequencer: checks each request against length and cursor, drives
// the entry memory to shift entries one per cycle, and builds the result.
// ----------------------------------------------------------------------------
module alc_ctrl #(
    parameter int CAPACITY = 64,
    parameter int SW       = 32,
    parameter int AW       = 6,
    parameter int UW       = 7
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  logic [3:0]                        operation,
    input  logic [alc_pkg::POS_PORT_W-1:0]    position,
    input  logic [alc_pkg::DATA_PORT_W-1:0]   value,
    output logic                              res_valid,
    input  logic                              res_ready,
    output alc_pkg::alc_result_t              res,
    output alc_pkg::alc_mem_ctl_t             mem_ctl,
    output logic [AW-1:0]                     mem_raddr,
    output logic [AW-1:0]                     mem_waddr,
    output logic [SW-1:0]                     mem_wdata,
    input  logic [SW-1:0]                     mem_rdata
);
    import alc_pkg::*;

    localparam int CMPW = (UW > POS_PORT_W) ? UW : POS_PORT_W;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_SHIFT_UP = 5'b00010,
        S_SHIFT_DN = 5'b00100,
        S_READ     = 5'b01000,
        S_DONE     = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    logic [UW-1:0] used_reg, used_next;
    logic [UW-1:0] cur_reg, cur_next;
    logic          started_reg, started_next;
    op_t           op_reg, op_next;
    logic [SW-1:0] val_reg, val_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] src_reg, src_next;
    logic [UW-1:0] n_reg, n_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    status_t       st_reg, st_next;
    logic [SW-1:0] data_reg, data_next;

    op_t             req_op;
    logic            full;
    logic            pos_ok;
    logic            cur_valid;
    logic [AW-1:0]   pos_idx;
    logic [CMPW-1:0] pos_wide;
    logic [CMPW-1:0] used_wide;

    // Decode the request against the current length and cursor
    assign req_op    = op_t'(operation);
    assign full      = (used_reg == UW'(CAPACITY));
    assign pos_wide  = CMPW'(position);
    assign used_wide = CMPW'(used_reg);
    assign pos_ok    = (pos_wide != '0) && (pos_wide <= used_wide);
    assign pos_idx   = AW'(pos_wide - CMPW'(1));
    assign cur_valid = started_reg && (cur_reg < used_reg);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        cur_next       = cur_reg;
        started_next   = started_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        idx_next       = idx_reg;
        src_next       = src_reg;
        n_next         = n_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        st_next        = st_reg;
        data_next      = data_reg;
        mem_ctl        = '0;
        mem_raddr      = '0;
        mem_waddr      = '0;
        mem_wdata      = val_reg;
        req_ready      = 1'b0;
        res_valid      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op_next    = req_op;
                    val_next   = value[SW-1:0];
                    st_next    = ST_OK;
                    data_next  = '0;
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                    case (req_op)
                        OP_INSERT:
                        begin
                            if (full)
                            begin
                                st_next = ST_FULL;
                            end
                            else if (!pos_ok)
                            begin
                                st_next = ST_BADPOS;
                            end
                            else
                            begin
                                idx_next   = pos_idx;
                                src_next   = AW'(used_reg - UW'(1));
                                n_next     = used_reg - UW'(pos_idx);
                                state_next = S_SHIFT_UP;
                            end
                        end
                        OP_APPEND:
                        begin
                            if (full)
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                mem_ctl.wr_en = 1'b1;
                                mem_waddr     = AW'(used_reg);
                                mem_wdata     = value[SW-1:0];
                                used_next     = used_reg + UW'(1);
                            end
                        end
                        OP_DELETE:
                        begin
                            if (!pos_ok)
                            begin
                                st_next = ST_BADPOS;
                            end
                            else
                            begin
                                idx_next   = pos_idx;
                                src_next   = pos_idx + AW'(1);
                                n_next     = used_reg - UW'(1) - UW'(pos_idx);
                                state_next = S_SHIFT_DN;
                            end
                        end
                        OP_READ:
                        begin
                            if (!pos_ok)
                            begin
                                st_next = ST_BADPOS;
                            end
                            else
                            begin
                                mem_ctl.rd_en = 1'b1;
                                mem_raddr     = pos_idx;
                                state_next    = S_READ;
                            end
                        end
                        OP_START:
                        begin
                            cur_next     = '0;
                            started_next = 1'b1;
                        end
                        OP_ADVANCE:
                        begin
                            if (!cur_valid)
                            begin
                                st_next = ST_BADCUR;
                            end
                            else
                            begin
                                cur_next = cur_reg + UW'(1);
                            end
                        end
                        OP_READ_CUR:
                        begin
                            if (!cur_valid)
                            begin
                                st_next = ST_BADCUR;
                            end
                            else
                            begin
                                mem_ctl.rd_en = 1'b1;
                                mem_raddr     = AW'(cur_reg);
                                state_next    = S_READ;
                            end
                        end
                        OP_ADD:
                        begin
                            if (full)
                            begin
                                st_next = ST_FULL;
                            end
                            else if (!cur_valid)
                            begin
                                st_next = ST_BADCUR;
                            end
                            else
                            begin
                                idx_next   = AW'(cur_reg);
                                src_next   = AW'(used_reg - UW'(1));
                                n_next     = used_reg - cur_reg;
                                state_next = S_SHIFT_UP;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (!cur_valid)
                            begin
                                st_next = ST_BADCUR;
                            end
                            else
                            begin
                                idx_next   = AW'(cur_reg);
                                src_next   = AW'(cur_reg + UW'(1));
                                n_next     = used_reg - UW'(1) - cur_reg;
                                state_next = S_SHIFT_DN;
                            end
                        end
                        default:
                        begin
                            st_next = ST_OK;
                        end
                    endcase
                end
            end

            S_SHIFT_UP:
            begin
                // Move the entry read last cycle up by one place
                if (pend_reg)
                begin
                    mem_ctl.wr_en = 1'b1;
                    mem_waddr     = pend_addr_reg + AW'(1);
                    mem_wdata     = mem_rdata;
                end
                // Read the next lower entry
                if (n_reg != '0)
                begin
                    mem_ctl.rd_en  = 1'b1;
                    mem_raddr      = src_reg;
                    src_next       = src_reg - AW'(1);
                    n_next         = n_reg - UW'(1);
                    pend_next      = 1'b1;
                    pend_addr_next = src_reg;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                // Drop the new entry into the hole
                if ((n_reg == '0) && !pend_reg)
                begin
                    mem_ctl.wr_en = 1'b1;
                    mem_waddr     = idx_reg;
                    mem_wdata     = val_reg;
                    used_next     = used_reg + UW'(1);
                    if (op_reg == OP_ADD)
                    begin
                        cur_next = cur_reg + UW'(1);
                    end
                    state_next = S_DONE;
                end
            end

            S_SHIFT_DN:
            begin
                // Move the entry read last cycle down by one place
                if (pend_reg)
                begin
                    mem_ctl.wr_en = 1'b1;
                    mem_waddr     = pend_addr_reg - AW'(1);
                    mem_wdata     = mem_rdata;
                end
                // Read the next higher entry
                if (n_reg != '0)
                begin
                    mem_ctl.rd_en  = 1'b1;
                    mem_raddr      = src_reg;
                    src_next       = src_reg + AW'(1);
                    n_next         = n_reg - UW'(1);
                    pend_next      = 1'b1;
                    pend_addr_next = src_reg;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                // Close the list once all moves are written
                if ((n_reg == '0) && !pend_reg)
                begin
                    used_next  = used_reg - UW'(1);
                    state_next = S_DONE;
                end
            end

            S_READ:
            begin
                data_next  = mem_rdata;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result fields come from the state after the operation
    always_comb
    begin
        res.data      = DATA_PORT_W'(data_reg);
        res.status    = st_reg;
        res.count     = used_wide[COUNT_PORT_W-1:0];
        res.cursor_ok = cur_valid;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            cur_reg     <= '0;
            started_reg <= 1'b0;
            n_reg       <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            cur_reg     <= cur_next;
            started_reg <= started_next;
            n_reg       <= n_next;
            pend_reg    <= pend_next;
        end
    end

    // Request payload and work pointers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        val_reg       <= val_next;
        idx_reg       <= idx_next;
        src_reg       <= src_next;
        pend_addr_reg <= pend_addr_next;
        st_reg        <= st_next;
        data_reg      <= data_next;
    end

`ifndef SYNTH
    // Length never exceeds the capacity
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UW'(CAPACITY))
        else $error("list length above capacity");

    // Cursor never runs past the capacity
    a_cur_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg <= UW'(CAPACITY))
        else $error("cursor above capacity");

    // Writes land inside the list or one past its end
    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.wr_en |-> (UW'(mem_waddr) <= used_reg))
        else $error("memory write beyond list end");

    // A shift never reads the entry it writes in the same cycle
    a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_ctl.rd_en && mem_ctl.wr_en) |-> (mem_raddr != mem_waddr))
        else $error("read and write collide on one entry");

    // Finishing an upward shift grows the list by one
    a_up_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT_UP && state_next == S_DONE)
        |=> (used_reg == $past(used_reg) + UW'(1)))
        else $error("insert did not grow the list");
`endif

endmodule

### tb/sv/alc_list_checker.sv
// ----------------------------------------------------------------------------
// alc_list_checker
// Watches the request and result channels of the ordered list, keeps its own
// copy of the list, length and cursor, works out the result of every accepted
// request and compares it field by field with the result the block returns.
// ----------------------------------------------------------------------------
module alc_list_checker #(
    parameter int CAPACITY = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    input  logic                               req_ready,
    input  logic [3:0]                         operation,
    input  logic [alc_pkg::POS_PORT_W-1:0]     position,
    input  logic [alc_pkg::DATA_PORT_W-1:0]    value,
    input  logic                               rsp_valid,
    input  logic                               rsp_ready,
    input  logic [alc_pkg::DATA_PORT_W-1:0]    data,
    input  logic [1:0]                         status,
    input  logic [alc_pkg::COUNT_PORT_W-1:0]   count,
    input  logic                               cursor_ok,
    output int                                 errors,
    output int                                 pending,
    output int                                 list_len
);

    timeunit 1ns;
    timeprecision 1ps;

    import alc_pkg::*;

    // Shadow copy of the list and its cursor
    logic [DATA_PORT_W-1:0] list_mem [CAPACITY];
    int                     list_used;
    int                     cur_idx;
    bit                     cur_started;

    // Results owed by the block, oldest first
    alc_result_t            owed_results [$];
    int                     fail_count;

    function automatic bit cursor_valid();
        return cur_started && (cur_idx < list_used);
    endfunction

    // Shift later entries up by one and write the new entry into the hole
    function automatic void open_slot(input int idx, input logic [DATA_PORT_W-1:0] v);
        for (int k = list_used; k > idx; k--)
            list_mem[k] = list_mem[k-1];
        list_mem[idx] = v;
        list_used++;
    endfunction

    // Shift later entries down by one over the removed entry
    function automatic void close_slot(input int idx);
        for (int k = idx; k + 1 < list_used; k++)
            list_mem[k] = list_mem[k+1];
        list_used--;
    endfunction

    // Apply one request to the shadow list and return the result it yields
    function automatic alc_result_t apply_list_op(input logic [3:0] op,
                                                  input logic [POS_PORT_W-1:0] pos,
                                                  input logic [DATA_PORT_W-1:0] val);
        alc_result_t res;
        bit          full;
        bit          pos_ok;
        int          p;
        res    = '0;
        res.status = ST_OK;
        p      = int'(pos);
        full   = (list_used >= CAPACITY);
        pos_ok = (p >= 1) && (p <= list_used);
        case (op)
            OP_INSERT:
                if (full)         res.status = ST_FULL;
                else if (!pos_ok) res.status = ST_BADPOS;
                else              open_slot(p - 1, val);
            OP_APPEND:
                if (full) res.status = ST_FULL;
                else      open_slot(list_used, val);
            OP_DELETE:
                if (!pos_ok) res.status = ST_BADPOS;
                else         close_slot(p - 1);
            OP_READ:
                if (!pos_ok) res.status = ST_BADPOS;
                else         res.data = list_mem[p - 1];
            OP_START:
            begin
                cur_idx     = 0;
                cur_started = 1'b1;
            end
            OP_ADVANCE:
                if (!cursor_valid()) res.status = ST_BADCUR;
                else                 cur_idx++;
            OP_READ_CUR:
                if (!cursor_valid()) res.status = ST_BADCUR;
                else                 res.data = list_mem[cur_idx];
            OP_ADD:
                if (full)                 res.status = ST_FULL;
                else if (!cursor_valid()) res.status = ST_BADCUR;
                else
                begin
                    // keep the cursor on the same entry
                    open_slot(cur_idx, val);
                    cur_idx++;
                end
            OP_REMOVE:
                if (!cursor_valid()) res.status = ST_BADCUR;
                else                 close_slot(cur_idx);
            default: ;
        endcase
        res.count     = list_used[COUNT_PORT_W-1:0];
        res.cursor_ok = cursor_valid();
        return res;
    endfunction

    function automatic void check_field(input string field,
                                        input logic [DATA_PORT_W-1:0] want,
                                        input logic [DATA_PORT_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, field, want, got);
            fail_count++;
        end
    endfunction

    // Retire results first, then record the new request
    always @(posedge clk or negedge rst_n)
    begin
        alc_result_t want;
        if (!rst_n)
        begin
            list_used   = 0;
            cur_idx     = 0;
            cur_started = 1'b0;
            fail_count  = 0;
            owed_results.delete();
            errors   <= 0;
            pending  <= 0;
            list_len <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (owed_results.size() == 0)
                begin
                    $display("%0t: result with no request waiting: data %0h status %0d count %0d",
                             $time, data, status, count);
                    fail_count++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    check_field("data", want.data, data);
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("count", 32'(want.count), 32'(count));
                    check_field("cursor_ok", 32'(want.cursor_ok), 32'(cursor_ok));
                end
            end
            if (req_valid && req_ready)
                owed_results.push_back(apply_list_op(operation, position, value));
            errors   <= fail_count;
            pending  <= owed_results.size();
            list_len <= list_used;
        end
    end

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the ordered list with a directed opening and then bursts of random
// requests that grow, shrink, walk the cursor or mix all operations, with
// random gaps on both channels; the checker beside the block judges results.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import alc_pkg::*;

    localparam int          LIST_CAP     = 64;
    localparam int          RANDOM_ITEMS = 1600;
    localparam int          SETTLE_TICKS = LIST_CAP + 16;
    localparam logic [3:0]  OP_UNUSED_LO = 4'd9;
    localparam logic [3:0]  OP_UNUSED_HI = 4'd15;

    typedef enum int {
        MODE_GROW,
        MODE_SHRINK,
        MODE_CURSOR,
        MODE_MIXED
    } burst_mode_t;

    logic                     clk;
    logic                     rst_n;
    logic                     req_valid;
    logic                     req_ready;
    logic [3:0]               operation;
    logic [POS_PORT_W-1:0]    position;
    logic [DATA_PORT_W-1:0]   value;
    logic                     rsp_valid;
    logic                     rsp_ready;
    logic [DATA_PORT_W-1:0]   data;
    logic [1:0]               status;
    logic [COUNT_PORT_W-1:0]  count;
    logic                     cursor_ok;

    int                       errors;
    int                       pending;
    int                       list_len;
    bit                       steady;

    array_list_with_cursor #(
        .CAPACITY   (LIST_CAP),
        .DATA_WIDTH (DATA_PORT_W)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .operation (operation),
        .position  (position),
        .value     (value),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .data      (data),
        .status    (status),
        .count     (count),
        .cursor_ok (cursor_ok)
    );

    alc_list_checker #(
        .CAPACITY (LIST_CAP)
    ) u_list_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .operation (operation),
        .position  (position),
        .value     (value),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .data      (data),
        .status    (status),
        .count     (count),
        .cursor_ok (cursor_ok),
        .errors    (errors),
        .pending   (pending),
        .list_len  (list_len)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #20_000_000;
        $display("array_list_with_cursor test failed");
        $finish;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 8);
    endfunction

    function automatic logic [3:0] pick_op(input burst_mode_t mode);
        int         r;
        logic [3:0] code;
        r    = $urandom_range(99, 0);
        code = 4'($urandom_range(15, 0));
        case (mode)
            MODE_GROW:
                if (r < 40)      code = OP_APPEND;
                else if (r < 65) code = OP_INSERT;
                else if (r < 80) code = OP_ADD;
                else if (r < 90) code = OP_START;
                else if (r < 95) code = OP_READ;
            MODE_SHRINK:
                if (r < 40)      code = OP_DELETE;
                else if (r < 65) code = OP_REMOVE;
                else if (r < 75) code = OP_START;
                else if (r < 85) code = OP_READ;
            MODE_CURSOR:
                if (r < 10)      code = OP_START;
                else if (r < 45) code = OP_ADVANCE;
                else if (r < 65) code = OP_READ_CUR;
                else if (r < 80) code = OP_ADD;
                else if (r < 95) code = OP_REMOVE;
            default:
                if (r < 90) code = 4'($urandom_range(OP_REMOVE, OP_INSERT));
        endcase
        return code;
    endfunction

    // Mostly a position inside the list, sometimes just outside, sometimes anything
    function automatic logic [POS_PORT_W-1:0] pick_position(input int len);
        int r;
        r = $urandom_range(99, 0);
        if (r < 80)
            return POS_PORT_W'($urandom_range((len < 1) ? 1 : len, 1));
        else if (r < 90)
            return POS_PORT_W'((r < 85) ? 0 : len + 1);
        else
            return POS_PORT_W'($urandom_range(127, 0));
    endfunction

    function automatic logic [DATA_PORT_W-1:0] pick_value();
        int r;
        r = $urandom_range(99, 0);
        if (r < 8)
            return '0;
        else if (r < 16)
            return '1;
        else
            return $urandom();
    endfunction

    // Hold off, then present one request and hold it until accepted
    task automatic send_request(input logic [3:0] op,
                                input logic [POS_PORT_W-1:0] pos,
                                input logic [DATA_PORT_W-1:0] val);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        operation <= op;
        position  <= pos;
        value     <= val;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    // Drop valid and wait until every owed result is back
    task automatic drain_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Result side: random stalls with long stretches of steady ready
    initial
    begin : rsp_side
        int r;
        rsp_ready = 1'b0;
        @(posedge clk);
        forever
        begin
            r = $urandom_range(99, 0);
            if (r < 20)
            begin
                rsp_ready <= 1'b1;
                repeat ($urandom_range(200, 50)) @(posedge clk);
            end
            else
            begin
                rsp_ready <= 1'b1;
                repeat ($urandom_range(8, 1)) @(posedge clk);
                rsp_ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge clk);
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        burst_mode_t mode;
        int          burst_len;
        int          list_items;
        logic [3:0]  op;

        rst_n      = 1'b0;
        req_valid  = 1'b0;
        operation  = '0;
        position   = '0;
        value      = '0;
        steady     = 1'b0;
        list_items = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list: every position and cursor operation but start must fail
        send_request(OP_INSERT,   7'd1,   32'h1111_1111);
        send_request(OP_DELETE,   7'd0,   32'h0);
        send_request(OP_READ,     7'd1,   32'h0);
        send_request(OP_START,    7'd0,   32'h0);
        send_request(OP_ADVANCE,  7'd0,   32'h0);
        send_request(OP_READ_CUR, 7'd0,   32'h0);
        send_request(OP_ADD,      7'd0,   32'h2222_2222);
        send_request(OP_REMOVE,   7'd0,   32'h0);
        send_request(OP_UNUSED_LO, 7'd5,  32'hDEAD_BEEF);
        send_request(OP_UNUSED_HI, 7'd127, 32'hFFFF_FFFF);

        // Build a short list and probe the position limits
        send_request(OP_APPEND,   7'd0,   32'h0000_0000);
        send_request(OP_APPEND,   7'd0,   32'hFFFF_FFFF);
        send_request(OP_INSERT,   7'd1,   32'hA5A5_A5A5);
        send_request(OP_INSERT,   7'd3,   32'h5A5A_5A5A);
        send_request(OP_READ,     7'd4,   32'h0);
        send_request(OP_READ,     7'd0,   32'h0);
        send_request(OP_READ,     7'd127, 32'h0);

        // Walk the cursor: add before it, delete before it, remove at it
        send_request(OP_START,    7'd0,   32'h0);
        send_request(OP_READ_CUR, 7'd0,   32'h0);
        send_request(OP_ADD,      7'd0,   32'h1234_5678);
        send_request(OP_ADVANCE,  7'd0,   32'h0);
        send_request(OP_DELETE,   7'd1,   32'h0);
        send_request(OP_REMOVE,   7'd0,   32'h0);
        send_request(OP_READ_CUR, 7'd0,   32'h0);
        send_request(OP_DELETE,   7'd64,  32'h0);

        drain_results();

        // Random bursts, each with its own flavor
        while (list_items < RANDOM_ITEMS)
        begin
            mode      = burst_mode_t'($urandom_range(MODE_MIXED, MODE_GROW));
            burst_len = (mode == MODE_GROW) ? $urandom_range(90, 40)
                                            : $urandom_range(40, 10);
            steady    = ($urandom_range(4, 0) == 0);
            if ($urandom_range(5, 0) == 0)
                drain_results();
            repeat (burst_len)
            begin
                op = pick_op(mode);
                send_request(op, pick_position(list_len), pick_value());
                if (op <= OP_REMOVE)
                    list_items++;
            end
        end

        // Wait for the tail, then let the block settle
        drain_results();
        repeat (SETTLE_TICKS) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("array_list_with_cursor test passed");
        else
            $display("array_list_with_cursor test failed");
        $finish;
    end

endmodule

### files.f
rtl/alc_pkg.sv
rtl/alc_store.sv
rtl/alc_ctrl.sv
rtl/array_list_with_cursor.sv
tb/sv/alc_list_checker.sv
tb/sv/tb.sv
